[design/quintic_quartic_boundary_solver_unit_defines.svh]
// Assertion macros used by the checker module qqbs_chk.
`ifndef QUINTIC_QUARTIC_BOUNDARY_SOLVER_UNIT_DEFINES_SVH
`define QUINTIC_QUARTIC_BOUNDARY_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QQBS_AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QQBS_AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/qqbs_pkg.sv]
package qqbs_pkg;
    localparam int INPUT_WIDTH_DEF = 32;
    localparam int COEFF_WIDTH_DEF = 48;
    localparam int HZN_W = 20;
    localparam logic [HZN_W-1:0] MIN_HZN_RST = 20'd6554;
    localparam int PRE_STAGES = 6;
    localparam int NUM_DIV = 5;
    localparam int NUM_LOW = 6;

    localparam int SH_POS = 33;
    localparam int SH_VEL = 17;
    localparam int SH_DV = 16;
    localparam int SH_C01 = 8;
    localparam int SH_C2 = 7;
    localparam int SH_LAT3 = 23;
    localparam int SH_LAT4 = 39;
    localparam int SH_LAT5 = 55;
    localparam int SH_LON3 = 24;
    localparam int SH_LON4 = 39;

    localparam int K_LAT3_A = 10;
    localparam int K_LAT3_B = 8;
    localparam int K_LAT4_A = 15;
    localparam int K_LAT4_B = 14;
    localparam int K_LAT4_D = 2;
    localparam int K_LAT5 = 6;
    localparam int K_LON3_A = 2;
    localparam int K_LON4_A = 3;
    localparam int K_LON4_B = 2;
endpackage

[design/qqbs_div.sv]
module qqbs_div import qqbs_pkg::*; #(
    parameter int NW = 80,
    parameter int SH = 24,
    parameter int DW = 60,
    parameter int QW = COEFF_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic [QW:0]   i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);
    localparam int TW = NW + SH;
    localparam int HIW = TW - QW;
    localparam int CW = (HIW > DW) ? HIW : DW;

    logic [TW-1:0]  dvd;
    logic [HIW-1:0] hi;
    logic [DW-1:0]  r_rem [0:QW-1];
    logic [DW-1:0]  r_den [0:QW-1];
    logic [QW-1:0]  r_x   [0:QW];
    logic           r_ovf [0:QW];

    assign dvd = {i_num, {SH{1'b0}}};
    assign hi = dvd[TW-1:QW];

    // The quotient always fits in QW bits unless the upper dividend part reaches the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= DW'(hi);
            r_x[0] <= dvd[QW-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= (CW'(hi) >= CW'(i_den));
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
        logic [DW:0] t;
        logic        ge;
        assign t = {r_rem[j-1], r_x[j-1][QW-1]};
        assign ge = (t >= {1'b0, r_den[j-1]});
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_x[j] <= {r_x[j-1][QW-2:0], ge};
                r_ovf[j] <= r_ovf[j-1];
            end
        end
        if (j < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= ge ? DW'(t - {1'b0, r_den[j-1]}) : t[DW-1:0];
                    r_den[j] <= r_den[j-1];
                end
            end
        end
    end

    assign o_quo = r_x[QW];
    assign o_ovf = r_ovf[QW];
endmodule

[design/quintic_quartic_boundary_solver_unit.sv]
// Throughput: one item per cycle while the output is not stalled by i_ready;
// the per-bit divider stages set the depth, not the rate.
// Each stage advances when it is empty or its successor advances, so bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and sets min_horizon to 6554.
module quintic_quartic_boundary_solver_unit import qqbs_pkg::*; #(
    parameter int INPUT_WIDTH = INPUT_WIDTH_DEF,
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [HZN_W-1:0]              i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [INPUT_WIDTH-1:0] i_lat_start_pos,
    input  logic signed [INPUT_WIDTH-1:0] i_lat_start_vel,
    input  logic signed [INPUT_WIDTH-1:0] i_lat_start_acc,
    input  logic signed [INPUT_WIDTH-1:0] i_lat_end_pos,
    input  logic signed [INPUT_WIDTH-1:0] i_lat_end_vel,
    input  logic signed [INPUT_WIDTH-1:0] i_lat_end_acc,
    input  logic signed [INPUT_WIDTH-1:0] i_lon_start_pos,
    input  logic signed [INPUT_WIDTH-1:0] i_lon_start_vel,
    input  logic signed [INPUT_WIDTH-1:0] i_lon_start_acc,
    input  logic signed [INPUT_WIDTH-1:0] i_lon_end_pos,
    input  logic signed [INPUT_WIDTH-1:0] i_lon_end_vel,
    input  logic [HZN_W-1:0]              i_horizon,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COEFF_WIDTH-1:0] o_lat_c0,
    output logic signed [COEFF_WIDTH-1:0] o_lat_c1,
    output logic signed [COEFF_WIDTH-1:0] o_lat_c2,
    output logic signed [COEFF_WIDTH-1:0] o_lat_c3,
    output logic signed [COEFF_WIDTH-1:0] o_lat_c4,
    output logic signed [COEFF_WIDTH-1:0] o_lat_c5,
    output logic signed [COEFF_WIDTH-1:0] o_lon_c0,
    output logic signed [COEFF_WIDTH-1:0] o_lon_c1,
    output logic signed [COEFF_WIDTH-1:0] o_lon_c2,
    output logic signed [COEFF_WIDTH-1:0] o_lon_c3,
    output logic signed [COEFF_WIDTH-1:0] o_lon_c4,
    output logic                          o_horizon_too_short
);
    localparam int W = INPUT_WIDTH;
    localparam int C = COEFF_WIDTH;
    localparam int H = HZN_W;
    localparam int DFW = W + 1;
    localparam int PW = W + H + 1;
    localparam int DHW = W + H + 2;
    localparam int AW = W + 2 * H + 4;
    localparam int BW = W + H + 3;
    localparam int D2W = W + 2 * H + 3;
    localparam int BHW = W + 2 * H + 4;
    localparam int NNW = W + 2 * H + 8;
    localparam int NS = PRE_STAGES + C + 2;
    localparam int SDW = NUM_LOW * C + 1;
    localparam int EW = ((W + SH_C01 > C) ? W + SH_C01 : C) + 1;
    localparam logic signed [EW-1:0] CMAX = EW'({1'b0, {(C-1){1'b1}}});
    localparam logic signed [EW-1:0] CMIN = ~CMAX;
    localparam logic [C-1:0] QMAX = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] QMIN = {1'b1, {(C-1){1'b0}}};

    logic [H-1:0]   r_min_hzn;
    logic [NS-1:0]  r_vld;
    logic [NS-1:0]  en;
    logic [SDW-1:0] n_side;
    logic [SDW-1:0] r_side [0:NS-2];
    logic [NUM_DIV-1:0] r_sgn [PRE_STAGES-1:NS-2];
    logic signed [W-1:0] cin [NUM_LOW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hzn <= MIN_HZN_RST;
        end else if (i_cfg_we) begin
            r_min_hzn <= i_cfg_wdata;
        end
    end

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];

    assign cin[0] = i_lat_start_pos;
    assign cin[1] = i_lat_start_vel;
    assign cin[2] = i_lat_start_acc;
    assign cin[3] = i_lon_start_pos;
    assign cin[4] = i_lon_start_vel;
    assign cin[5] = i_lon_start_acc;

    // The low coefficients are plain rescaled inputs, saturated to the output range.
    always_comb begin
        logic signed [EW-1:0] v;
        n_side[0] = (i_horizon == '0) || (i_horizon < r_min_hzn);
        for (int i = 0; i < NUM_LOW; i++) begin
            v = EW'(cin[i]) <<< ((i == 2 || i == 5) ? SH_C2 : SH_C01);
            if (v > CMAX) begin
                n_side[1 + i * C +: C] = CMAX[C-1:0];
            end else if (v < CMIN) begin
                n_side[1 + i * C +: C] = CMIN[C-1:0];
            end else begin
                n_side[1 + i * C +: C] = v[C-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= n_side;
        end
    end

    for (genvar s = 1; s <= NS - 2; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Stage 0: register the horizon, the boundary differences and the start velocities and accelerations.
    logic [H-1:0] r0_h;
    logic signed [DFW-1:0] r0_lp_d, r0_lv_d, r0_la_d, r0_sp_d, r0_sv_d;
    logic signed [W-1:0] r0_ldx0, r0_lddx0, r0_sdx0, r0_sddx0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_h <= i_horizon;
            r0_lp_d <= DFW'(i_lat_end_pos) - DFW'(i_lat_start_pos);
            r0_lv_d <= DFW'(i_lat_end_vel) - DFW'(i_lat_start_vel);
            r0_la_d <= DFW'(i_lat_end_acc) - DFW'(i_lat_start_acc);
            r0_sp_d <= DFW'(i_lon_end_pos) - DFW'(i_lon_start_pos);
            r0_sv_d <= DFW'(i_lon_end_vel) - DFW'(i_lon_start_vel);
            r0_ldx0 <= i_lat_start_vel;
            r0_lddx0 <= i_lat_start_acc;
            r0_sdx0 <= i_lon_start_vel;
            r0_sddx0 <= i_lon_start_acc;
        end
    end

    // Stage 1: first products with the horizon.
    logic signed [H:0] hs0, hs1, hs2;
    logic [H-1:0] r1_h;
    logic [2*H-1:0] r1_h2;
    logic signed [DFW-1:0] r1_lp_d, r1_lv_d, r1_sp_d, r1_sv_d;
    logic signed [PW-1:0] r1_lp1, r1_lp2, r1_sp1, r1_sp2;
    logic signed [DHW-1:0] r1_ldh;

    assign hs0 = $signed({1'b0, r0_h});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_h <= r0_h;
            r1_h2 <= r0_h * r0_h;
            r1_lp_d <= r0_lp_d;
            r1_lv_d <= r0_lv_d;
            r1_sp_d <= r0_sp_d;
            r1_sv_d <= r0_sv_d;
            r1_lp1 <= r0_ldx0 * hs0;
            r1_lp2 <= r0_lddx0 * hs0;
            r1_sp1 <= r0_sdx0 * hs0;
            r1_sp2 <= r0_sddx0 * hs0;
            r1_ldh <= r0_la_d * hs0;
        end
    end

    // Stage 2: the A and B terms.
    logic [H-1:0] r2_h;
    logic [3*H-1:0] r2_h3;
    logic signed [AW-1:0] r2_la, r2_sa;
    logic signed [BW-1:0] r2_lb, r2_sb;
    logic signed [D2W-1:0] r2_ld2;

    assign hs1 = $signed({1'b0, r1_h});

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_h <= r1_h;
            r2_h3 <= r1_h2 * r1_h;
            r2_la <= (AW'(r1_lp_d) <<< SH_POS) - (AW'(r1_lp1) <<< SH_VEL)
                     - AW'(r1_lp2) * hs1;
            r2_sa <= (AW'(r1_sp_d) <<< SH_POS) - (AW'(r1_sp1) <<< SH_VEL)
                     - AW'(r1_sp2) * hs1;
            r2_lb <= (BW'(r1_lv_d) <<< SH_DV) - BW'(r1_lp2);
            r2_sb <= (BW'(r1_sv_d) <<< SH_DV) - BW'(r1_sp2);
            r2_ld2 <= r1_ldh * hs1;
        end
    end

    // Stage 3: B times the horizon.
    logic [H-1:0] r3_h;
    logic [3*H-1:0] r3_h3;
    logic [4*H-1:0] r3_h4;
    logic signed [AW-1:0] r3_la, r3_sa;
    logic signed [BHW-1:0] r3_lbh, r3_sbh;
    logic signed [D2W-1:0] r3_ld2;

    assign hs2 = $signed({1'b0, r2_h});

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_h <= r2_h;
            r3_h3 <= r2_h3;
            r3_h4 <= r2_h3 * r2_h;
            r3_la <= r2_la;
            r3_sa <= r2_sa;
            r3_lbh <= r2_lb * hs2;
            r3_sbh <= r2_sb * hs2;
            r3_ld2 <= r2_ld2;
        end
    end

    // Stage 4: the numerators.
    logic [3*H-1:0] r4_h3;
    logic [4*H-1:0] r4_h4;
    logic [5*H-1:0] r4_h5;
    logic signed [NNW-1:0] r4_n [NUM_DIV];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_h3 <= r3_h3;
            r4_h4 <= r3_h4;
            r4_h5 <= r3_h4 * r3_h;
            r4_n[0] <= NNW'(r3_la) * K_LAT3_A - NNW'(r3_lbh) * K_LAT3_B + NNW'(r3_ld2);
            r4_n[1] <= NNW'(r3_lbh) * K_LAT4_B - NNW'(r3_la) * K_LAT4_A
                       - NNW'(r3_ld2) * K_LAT4_D;
            r4_n[2] <= NNW'(r3_la) * K_LAT5 - NNW'(r3_lbh) * K_LAT5 + NNW'(r3_ld2);
            r4_n[3] <= NNW'(r3_sa) * K_LON3_A - NNW'(r3_sbh);
            r4_n[4] <= NNW'(r3_sbh) * K_LON4_B - NNW'(r3_sa) * K_LON4_A;
        end
    end

    // Stage 5: sign and magnitude.
    logic [3*H-1:0] r5_h3;
    logic [4*H-1:0] r5_h4;
    logic [5*H-1:0] r5_h5;
    logic [NNW-1:0] r5_m [NUM_DIV];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_h3 <= r4_h3;
            r5_h4 <= r4_h4;
            r5_h5 <= r4_h5;
            for (int k = 0; k < NUM_DIV; k++) begin
                r5_m[k] <= r4_n[k][NNW-1] ? NNW'(-r4_n[k]) : NNW'(r4_n[k]);
                r_sgn[PRE_STAGES-1][k] <= r4_n[k][NNW-1];
            end
        end
    end

    for (genvar s = PRE_STAGES; s <= NS - 2; s++) begin : g_sgn
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_sgn[s] <= r_sgn[s-1];
            end
        end
    end

    logic [C-1:0]       div_q [NUM_DIV];
    logic [NUM_DIV-1:0] div_ovf;

    qqbs_div #(.NW(NNW), .SH(SH_LAT3 + 1), .DW(3 * H), .QW(C)) u_div_lat3 (
        .i_clk (i_clk), .i_en (en[PRE_STAGES +: C + 1]), .i_num (r5_m[0]),
        .i_den (r5_h3), .o_quo (div_q[0]), .o_ovf (div_ovf[0])
    );
    qqbs_div #(.NW(NNW), .SH(SH_LAT4 + 1), .DW(4 * H), .QW(C)) u_div_lat4 (
        .i_clk (i_clk), .i_en (en[PRE_STAGES +: C + 1]), .i_num (r5_m[1]),
        .i_den (r5_h4), .o_quo (div_q[1]), .o_ovf (div_ovf[1])
    );
    qqbs_div #(.NW(NNW), .SH(SH_LAT5 + 1), .DW(5 * H), .QW(C)) u_div_lat5 (
        .i_clk (i_clk), .i_en (en[PRE_STAGES +: C + 1]), .i_num (r5_m[2]),
        .i_den (r5_h5), .o_quo (div_q[2]), .o_ovf (div_ovf[2])
    );
    qqbs_div #(.NW(NNW), .SH(SH_LON3 + 1), .DW(3 * H), .QW(C)) u_div_lon3 (
        .i_clk (i_clk), .i_en (en[PRE_STAGES +: C + 1]), .i_num (r5_m[3]),
        .i_den (r5_h3), .o_quo (div_q[3]), .o_ovf (div_ovf[3])
    );
    qqbs_div #(.NW(NNW), .SH(SH_LON4 + 1), .DW(4 * H), .QW(C)) u_div_lon4 (
        .i_clk (i_clk), .i_en (en[PRE_STAGES +: C + 1]), .i_num (r5_m[4]),
        .i_den (r5_h4), .o_quo (div_q[4]), .o_ovf (div_ovf[4])
    );

    // The dividers return floor(2N/D); adding one and halving rounds half away from zero.
    logic [C-1:0] n_hi [NUM_DIV];

    always_comb begin
        logic [C-1:0] rr;
        logic         sat;
        for (int k = 0; k < NUM_DIV; k++) begin
            sat = div_ovf[k] || (&div_q[k]);
            rr = {1'b0, div_q[k][C-1:1]} + C'(div_q[k][0]);
            if (r_side[NS-2][0]) begin
                n_hi[k] = '0;
            end else if (sat) begin
                n_hi[k] = r_sgn[NS-2][k] ? QMIN : QMAX;
            end else begin
                n_hi[k] = r_sgn[NS-2][k] ? {C{1'b0}} - rr : rr;
            end
        end
    end

    logic [C-1:0] r_oc_lo [NUM_LOW];
    logic [C-1:0] r_oc_hi [NUM_DIV];
    logic         r_o_shrt;

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_o_shrt <= r_side[NS-2][0];
            for (int i = 0; i < NUM_LOW; i++) begin
                r_oc_lo[i] <= r_side[NS-2][1 + i * C +: C];
            end
            for (int k = 0; k < NUM_DIV; k++) begin
                r_oc_hi[k] <= n_hi[k];
            end
        end
    end

    assign o_lat_c0 = r_oc_lo[0];
    assign o_lat_c1 = r_oc_lo[1];
    assign o_lat_c2 = r_oc_lo[2];
    assign o_lon_c0 = r_oc_lo[3];
    assign o_lon_c1 = r_oc_lo[4];
    assign o_lon_c2 = r_oc_lo[5];
    assign o_lat_c3 = r_oc_hi[0];
    assign o_lat_c4 = r_oc_hi[1];
    assign o_lat_c5 = r_oc_hi[2];
    assign o_lon_c3 = r_oc_hi[3];
    assign o_lon_c4 = r_oc_hi[4];
    assign o_horizon_too_short = r_o_shrt;
endmodule

[design/qqbs_chk.sv]
`include "quintic_quartic_boundary_solver_unit_defines.svh"

module qqbs_chk import qqbs_pkg::*; #(
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [COEFF_WIDTH-1:0] o_lat_c3,
    input logic [COEFF_WIDTH-1:0] o_lat_c4,
    input logic [COEFF_WIDTH-1:0] o_lat_c5,
    input logic [COEFF_WIDTH-1:0] o_lon_c3,
    input logic [COEFF_WIDTH-1:0] o_lon_c4,
    input logic                   o_horizon_too_short
);
    `QQBS_AST_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_lat_c5) && $stable(o_lon_c4) && $stable(o_horizon_too_short), "stalled result item changed")
    `QQBS_AST_IMP(a_short_zero, i_clk, i_rst_n, o_valid && o_horizon_too_short, o_lat_c3 == '0 && o_lat_c4 == '0 && o_lat_c5 == '0 && o_lon_c3 == '0 && o_lon_c4 == '0, "short horizon item has nonzero higher coefficients")
    `QQBS_AST_IMP(a_full_stall, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "input blocked while the pipeline can still advance")
endmodule

bind quintic_quartic_boundary_solver_unit qqbs_chk #(.COEFF_WIDTH(COEFF_WIDTH)) u_qqbs_chk (.*);

[verif/testbench.sv]
module testbench;
    import qqbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 11;
    localparam int NC = 11;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic signed [31:0] f[NF];
        logic [HZN_W-1:0]   h;
    } t_sample;

    typedef struct {
        logic [47:0] c[NC];
        logic        short_hzn;
    } t_coeffs;

    typedef struct {
        t_sample s;
        bit      typed;
        t_coeffs r;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [HZN_W-1:0]         i_cfg_wdata;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [31:0]       drv_f[NF];
    logic [HZN_W-1:0]         i_horizon;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [47:0]       o_c[NC];
    logic                     o_horizon_too_short;

    logic [HZN_W-1:0] min_hzn;
    t_coeffs          pending_q[$];
    t_row             directed[$];
    int               errors;
    int               idle_cycles;
    bit               calm;
    bit               hold_req;
    int               hold_cnt;

    quintic_quartic_boundary_solver_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_lat_start_pos(drv_f[0]), .i_lat_start_vel(drv_f[1]),
        .i_lat_start_acc(drv_f[2]), .i_lat_end_pos(drv_f[3]),
        .i_lat_end_vel(drv_f[4]), .i_lat_end_acc(drv_f[5]),
        .i_lon_start_pos(drv_f[6]), .i_lon_start_vel(drv_f[7]),
        .i_lon_start_acc(drv_f[8]), .i_lon_end_pos(drv_f[9]),
        .i_lon_end_vel(drv_f[10]), .i_horizon(i_horizon),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_lat_c0(o_c[0]), .o_lat_c1(o_c[1]), .o_lat_c2(o_c[2]),
        .o_lat_c3(o_c[3]), .o_lat_c4(o_c[4]), .o_lat_c5(o_c[5]),
        .o_lon_c0(o_c[6]), .o_lon_c1(o_c[7]), .o_lon_c2(o_c[8]),
        .o_lon_c3(o_c[9]), .o_lon_c4(o_c[10]),
        .o_horizon_too_short(o_horizon_too_short)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Rounds num/den to nearest with ties away from zero, then clamps to 48 bits.
    function automatic logic [47:0] round_clamp(t_wide num, logic [255:0] den);
        logic         neg;
        logic [255:0] mag;
        logic [255:0] q;
        logic [255:0] rem;
        neg = num[255];
        mag = neg ? -num : num;
        q = mag / den;
        rem = mag % den;
        if ((rem << 1) >= den) q = q + 1;
        if (neg) begin
            if (q > (256'd1 << 47)) q = 256'd1 << 47;
            return -q[47:0];
        end
        if (q > ((256'd1 << 47) - 1)) q = (256'd1 << 47) - 1;
        return q[47:0];
    endfunction

    function automatic t_coeffs solve_coeffs(t_sample s);
        t_coeffs      r;
        t_wide        v[NF];
        t_wide        hh;
        t_wide        a;
        t_wide        b;
        t_wide        bh;
        t_wide        dh2;
        logic [255:0] h3;
        logic [255:0] h4;
        logic [255:0] h5;
        for (int i = 0; i < NF; i++) v[i] = s.f[i];
        hh = {236'd0, s.h};
        h3 = hh * hh * hh;
        h4 = h3 * hh;
        h5 = h4 * hh;
        r.c[0] = round_clamp(v[0] <<< 8, 1);
        r.c[1] = round_clamp(v[1] <<< 8, 1);
        r.c[2] = round_clamp(v[2] <<< 7, 1);
        r.c[6] = round_clamp(v[6] <<< 8, 1);
        r.c[7] = round_clamp(v[7] <<< 8, 1);
        r.c[8] = round_clamp(v[8] <<< 7, 1);
        r.short_hzn = (s.h == 0) || (s.h < min_hzn);
        for (int k = 3; k <= 5; k++) r.c[k] = '0;
        r.c[9] = '0;
        r.c[10] = '0;
        if (!r.short_hzn) begin
            a = ((v[3] - v[0]) <<< 33) - ((v[1] * hh) <<< 17) - v[2] * hh * hh;
            b = ((v[4] - v[1]) <<< 16) - v[2] * hh;
            bh = b * hh;
            dh2 = (v[5] - v[2]) * hh * hh;
            r.c[3] = round_clamp((10 * a - 8 * bh + dh2) <<< 23, h3);
            r.c[4] = round_clamp((14 * bh - 15 * a - 2 * dh2) <<< 39, h4);
            r.c[5] = round_clamp((6 * a - 6 * bh + dh2) <<< 55, h5);
            a = ((v[9] - v[6]) <<< 33) - ((v[7] * hh) <<< 17) - v[8] * hh * hh;
            b = ((v[10] - v[7]) <<< 16) - v[8] * hh;
            bh = b * hh;
            r.c[9] = round_clamp((2 * a - bh) <<< 24, h3);
            r.c[10] = round_clamp((2 * bh - 3 * a) <<< 39, h4);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(5))
            0: return $urandom_range(255) - 128;
            1: return ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return $urandom_range(131072) - 65536;
            3: return $urandom_range(4194304) - 2097152;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        for (int i = 0; i < NF; i++) s.f[i] = rand_field();
        case ($urandom_range(9))
            0: s.h = HZN_W'($urandom_range(min_hzn));
            1: s.h = min_hzn;
            2: s.h = '1;
            3: s.h = HZN_W'($urandom);
            default: s.h = HZN_W'((min_hzn > 20'd600000) ? $urandom_range(20'hFFFFF, min_hzn)
                                                         : $urandom_range(600000, min_hzn));
        endcase
        return s;
    endfunction

    task automatic write_min_horizon(logic [HZN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        min_hzn = val;
    endtask

    task automatic send_sample(t_sample s, bit typed, t_coeffs want);
        if (!calm && $urandom_range(99) < 13) begin
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        for (int i = 0; i < NF; i++) drv_f[i] = s.f[i];
        i_horizon = s.h;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_q = {pending_q, typed ? want : solve_coeffs(s)};
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_sample(rand_sample(), 1'b0, '{default: 0});
    endtask

    function automatic t_row make_row(logic signed [31:0] val, logic [HZN_W-1:0] h);
        t_row r;
        for (int i = 0; i < NF; i++) r.s.f[i] = val;
        r.s.h = h;
        r.typed = 1'b0;
        return r;
    endfunction

    // Short-horizon rows whose coefficients can be written down directly.
    function automatic t_row typed_row(logic signed [31:0] val, logic [HZN_W-1:0] h);
        t_row r;
        r = make_row(val, h);
        r.typed = 1'b1;
        for (int i = 0; i < NC; i++) r.r.c[i] = '0;
        r.r.c[0] = {{8{val[31]}}, val, 8'd0};
        r.r.c[1] = r.r.c[0];
        r.r.c[2] = {{9{val[31]}}, val, 7'd0};
        r.r.c[6] = r.r.c[0];
        r.r.c[7] = r.r.c[0];
        r.r.c[8] = r.r.c[2];
        r.r.short_hzn = 1'b1;
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        t_coeffs want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result item with no expectation pending", $realtime);
                errors++;
            end else begin
                want = pending_q.pop_front();
                for (int i = 0; i < NC; i++) begin
                    if (o_c[i] !== want.c[i]) begin
                        $display("%0t: coeff %0d expected %h actual %h",
                                 $realtime, i, want.c[i], o_c[i]);
                        errors++;
                    end
                end
                if (o_horizon_too_short !== want.short_hzn) begin
                    $display("%0t: short flag expected %b actual %b",
                             $realtime, want.short_hzn, o_horizon_too_short);
                    errors++;
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_row spare;
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_cnt = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_horizon = '0;
        for (int i = 0; i < NF; i++) drv_f[i] = '0;
        min_hzn = MIN_HZN_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = {directed, typed_row(32'sd0, 20'd0)};
        directed = {directed, typed_row(32'sh7FFF_FFFF, 20'd0)};
        directed = {directed, typed_row(32'sh8000_0000, 20'd0)};
        directed = {directed, typed_row(32'sh7FFF_FFFF, 20'd6553)};
        directed = {directed, typed_row(-32'sd1, 20'd1)};
        directed = {directed, make_row(32'sd0, 20'd6554)};
        directed = {directed, make_row(32'sh7FFF_FFFF, 20'd6554)};
        directed = {directed, make_row(32'sh8000_0000, 20'd6554)};
        directed = {directed, make_row(32'sh7FFF_FFFF, 20'hFFFFF)};
        directed = {directed, make_row(32'sh8000_0000, 20'hFFFFF)};
        directed = {directed, make_row(32'sd65536, 20'd65536)};
        directed = {directed, make_row(-32'sd65536, 20'd131072)};
        for (int i = 0; i < 6; i++) begin
            t_row r;
            r = make_row(32'sd0, 20'd65536);
            r.s.f[i] = 32'sd65536;
            r.s.f[6 + (i % 5)] = -32'sd65536;
            directed = {directed, r};
        end
        foreach (directed[i]) send_sample(directed[i].s, directed[i].typed, directed[i].r);
        send_random(250);

        drain();
        write_min_horizon(20'd1);
        spare = make_row(32'sh7FFF_FFFF, 20'd1);
        send_sample(spare.s, 1'b0, '{default: 0});
        spare = make_row(32'sh8000_0000, 20'd1);
        send_sample(spare.s, 1'b0, '{default: 0});
        send_random(300);
        hold_req = 1'b1;
        send_random(200);

        drain();
        write_min_horizon(20'hFFFFF);
        send_random(200);

        drain();
        write_min_horizon(20'd0);
        spare = make_row(32'sd12345, 20'd0);
        send_sample(spare.s, 1'b0, '{default: 0});
        send_random(150);

        drain();
        write_min_horizon(20'd6554);
        calm = 1'b1;
        send_random(300);
        calm = 1'b0;

        drain();
        write_min_horizon(HZN_W'($urandom_range(20'hFFFFF, 1)));
        send_random(250);

        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
